[design/tbsm_pkg.sv]
`default_nettype none

package tbsm_pkg;

   // Request kinds carried on the input channel's tuser
   localparam logic [1:0] REQ_TICK  = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_WRITE = 2'd2;

   // Bits shifted out per transaction
   localparam logic [4:0] READ_BITS  = 5'd8;
   localparam logic [4:0] WRITE_BITS = 5'd16;

   // Payload widths of the two channels
   localparam int ReqDataWidth = 16;
   localparam int ReqUserWidth = 2;
   localparam int RspDataWidth = 16;

   // Decimal to BCD for values below 128.
   // The tens digit comes from a multiply by 205/2048, which is exact here,
   // and for values of 100 and above the high nibble holds 10 to 12, which is not a BCD digit.
   function automatic logic [7:0] to_bcd(input logic [6:0] dec);
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [6:0]  tens_x10;
      logic [6:0]  units;
      prod     = 15'(dec) * 15'd205;
      tens     = prod[14:11];
      tens_x10 = 7'({tens, 3'b000}) + 7'({tens, 1'b0});
      units    = dec - tens_x10;
      return {tens, units[3:0]};
   endfunction

   // BCD to decimal; bit 7 is kept, so the result runs up to 165
   function automatic logic [7:0] from_bcd(input logic [7:0] bcd);
      logic [7:0] hi_x10;
      hi_x10 = {1'b0, bcd[7:4], 3'b000} + {3'b000, bcd[7:4], 1'b0};
      return hi_x10 + {4'b0000, bcd[3:0]};
   endfunction

endpackage

`default_nettype wire

[design/three_wire_bcd_serial_master.sv]
`default_nettype none

// Channel  Direction  tdata / tuser contents
// req      in         tdata: command_byte, write_value, data_pin_in; tuser: req_type
// rsp      out        tdata: chip_enable .. read_value (one result per tick)
//
// Every accepted tick produces exactly one result, held in the result register.
// A new tick is accepted every cycle while no result waits untaken; the single result register sets that rate.
// The result register refills while its contents are being taken, so a stall
// on the result side stalls the input side only while a result waits.
// Reset is synchronous and returns the bus sequencer to idle with the pin driven.

module three_wire_bcd_serial_master
   import tbsm_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output      logic                    req_tready,
   // [7:0] command_byte, [14:8] write_value, [15] data_pin_in
   input  wire logic [ReqDataWidth-1:0] req_tdata,
   // [1:0] req_type
   input  wire logic [ReqUserWidth-1:0] req_tuser,
   output      logic                    rsp_tvalid,
   input  wire logic                    rsp_tready,
   // [0] chip_enable, [1] serial_clock, [2] data_pin_out, [3] data_drive,
   // [4] busy_res, [5] done_res, [13:6] read_value, [15:14] zero
   output      logic [RspDataWidth-1:0] rsp_tdata
);

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_SEND_LOW  = 3'd1,
      PH_SEND_HIGH = 3'd2,
      PH_RECV_HIGH = 3'd3,
      PH_RECV_LOW  = 3'd4,
      PH_FINISH    = 3'd5
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [4:0]  bit_count_ff, bit_count_in;
   logic [15:0] out_shift_ff, out_shift_in;
   logic [7:0]  in_shift_ff, in_shift_in;
   logic        is_read_ff, is_read_in;
   logic        rsp_valid_ff;
   logic [RspDataWidth-1:0] rsp_data_ff, rsp_data_in;

   logic [1:0]  req_type;
   logic [7:0]  command_byte;
   logic [6:0]  write_value;
   logic        data_pin_in;
   logic        accept;
   logic [2:0]  sample_idx;
   logic [7:0]  final_byte;

   logic ce, clk, dout, drive, busy, done;
   logic [7:0] read_value;

   // Unpack the input transfer
   assign req_type     = req_tuser;
   assign command_byte = req_tdata[7:0];
   assign write_value  = req_tdata[14:8];
   assign data_pin_in  = req_tdata[15];

   // The input side moves whenever the result register is free or being emptied
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign sample_idx = 3'(bit_count_ff - 5'd1);
   assign final_byte = in_shift_ff | {data_pin_in, 7'b0000000};

   // Bus sequencer: outputs and next state for one half-bit tick
   always_comb begin
      phase_in     = phase_ff;
      bit_count_in = bit_count_ff;
      out_shift_in = out_shift_ff;
      in_shift_in  = in_shift_ff;
      is_read_in   = is_read_ff;
      ce           = 1'b0;
      clk          = 1'b0;
      dout         = 1'b0;
      drive        = 1'b0;
      busy         = 1'b0;
      done         = 1'b0;
      read_value   = 8'd0;
      unique case (phase_ff)
         PH_SEND_LOW: begin
            ce       = 1'b1;
            dout     = out_shift_ff[0];
            drive    = 1'b1;
            busy     = 1'b1;
            phase_in = PH_SEND_HIGH;
         end
         PH_SEND_HIGH: begin
            ce           = 1'b1;
            clk          = 1'b1;
            dout         = out_shift_ff[0];
            drive        = 1'b1;
            busy         = 1'b1;
            out_shift_in = {1'b0, out_shift_ff[15:1]};
            bit_count_in = bit_count_ff - 5'd1;
            if (bit_count_in == 5'd0) begin
               if (is_read_ff) begin
                  in_shift_in = 8'd0;
                  phase_in    = PH_RECV_HIGH;
               end else begin
                  phase_in = PH_FINISH;
               end
            end else begin
               phase_in = PH_SEND_LOW;
            end
         end
         PH_RECV_HIGH: begin
            // The first high tick of the read phase samples nothing
            if (bit_count_ff != 5'd0) begin
               in_shift_in = in_shift_ff | (8'(data_pin_in) << sample_idx);
            end
            ce       = 1'b1;
            clk      = 1'b1;
            busy     = 1'b1;
            phase_in = PH_RECV_LOW;
         end
         PH_RECV_LOW: begin
            ce           = 1'b1;
            busy         = 1'b1;
            bit_count_in = bit_count_ff + 5'd1;
            phase_in     = (bit_count_in >= READ_BITS) ? PH_FINISH : PH_RECV_HIGH;
         end
         PH_FINISH: begin
            // The last data bit is sampled on the closing tick
            if (is_read_ff) begin
               in_shift_in = final_byte;
               read_value  = from_bcd(final_byte);
            end
            drive        = !is_read_ff;
            busy         = 1'b1;
            done         = 1'b1;
            bit_count_in = 5'd0;
            phase_in     = PH_IDLE;
         end
         default: begin
            drive    = !is_read_ff;
            phase_in = PH_IDLE;
            if (req_type == REQ_READ || req_type == REQ_WRITE) begin
               ce         = 1'b1;
               busy       = 1'b1;
               is_read_in = (req_type == REQ_READ);
               if (req_type == REQ_READ) begin
                  out_shift_in = {8'd0, command_byte};
                  bit_count_in = READ_BITS;
               end else begin
                  out_shift_in = {to_bcd(write_value), command_byte};
                  bit_count_in = WRITE_BITS;
               end
               phase_in = PH_SEND_LOW;
            end
         end
      endcase
      rsp_data_in = {2'b00, read_value, done, busy, drive, dout, clk, ce};
   end

   // State and the result register advance on each accepted tick
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         bit_count_ff <= 5'd0;
         out_shift_ff <= 16'd0;
         in_shift_ff  <= 8'd0;
         is_read_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff     <= phase_in;
            bit_count_ff <= bit_count_in;
            out_shift_ff <= out_shift_in;
            in_shift_ff  <= in_shift_in;
            is_read_ff   <= is_read_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // A finished transaction closes the bus: chip enable and clock are low, busy is still high
   a_done_closes_bus: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[5] |-> !rsp_data_ff[0] && !rsp_data_ff[1] && rsp_data_ff[4])
      else $error("done result with the bus still open");

   // A clock pulse is only ever issued inside a transaction
   a_clock_in_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[1] |-> rsp_data_ff[0] && rsp_data_ff[4])
      else $error("serial clock high outside a transaction");

   // Read data appears only on the closing tick of a transaction
   a_read_value_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[13:6] != 8'd0 |-> rsp_data_ff[5])
      else $error("read value shown outside the closing tick");

   // With the pin released the master drives no data level
   a_released_pin_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff[3] |-> !rsp_data_ff[2])
      else $error("data level set while the pin is released");

endmodule

`default_nettype wire
